[src/pbs_pkg.sv]
`default_nettype none
package pbs_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth = 16;

  // register indexes on the config channel
  localparam logic [CfgIndexWidth-1:0] REG_PRESS_THRESHOLD = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_HOLD_THRESHOLD  = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_PULSE_LENGTH    = 2'd2;

  localparam logic [CountWidth-1:0] PRESS_THRESHOLD_RESET = 16'd10;
  localparam logic [CountWidth-1:0] HOLD_THRESHOLD_RESET  = 16'd2000;
  localparam logic [CountWidth-1:0] PULSE_LENGTH_RESET    = 16'd30;

  // button phase codes; the fourth code behaves as held
  localparam logic [1:0] PHASE_RELEASED = 2'd0;
  localparam logic [1:0] PHASE_PRESSED  = 2'd1;
  localparam logic [1:0] PHASE_HELD     = 2'd2;

  typedef struct packed {
    logic press;
    logic hold;
  } button_event_t;

  typedef logic [CountWidth-1:0] count_t;

  function automatic count_t sat_inc(input count_t v);
    sat_inc = (v == '1) ? v : count_t'(v + 1'b1);
  endfunction

endpackage
`default_nettype wire

[src/pbs_if.sv]
`default_nettype none
interface pbs_tick_if;
  logic valid;
  logic ready;
  logic button_level;
  logic remote_request;
  logic shutdown_done;

  modport source (output valid, output button_level, output remote_request,
                  output shutdown_done, input ready);
  modport sink (input valid, input button_level, input remote_request,
                input shutdown_done, output ready);
endinterface

interface pbs_result_if;
  logic valid;
  logic ready;
  logic regulators_enabled;
  logic power_request_line;
  logic press_event;
  logic hold_event;

  modport source (output valid, output regulators_enabled, output power_request_line,
                  output press_event, output hold_event, input ready);
  modport sink (input valid, input regulators_enabled, input power_request_line,
                input press_event, input hold_event, output ready);
endinterface

interface pbs_cfg_if;
  logic valid;
  logic ready;
  logic [pbs_pkg::CfgIndexWidth-1:0] index;
  logic [pbs_pkg::CfgDataWidth-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[src/pbs_button.sv]
`default_nettype none
module pbs_button (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  advance,
  input  wire logic                  level,
  input  wire pbs_pkg::count_t       press_threshold,
  input  wire pbs_pkg::count_t       hold_threshold,
  output pbs_pkg::button_event_t     events
);

  logic            last_level;
  logic [1:0]      phase;
  pbs_pkg::count_t ticks;

  logic            changed;
  logic [1:0]      phase_cur;
  logic [1:0]      phase_next;
  pbs_pkg::count_t ticks_next;

  always_comb begin
    changed = (level != last_level);
    ticks_next = changed ? '0 : pbs_pkg::sat_inc(ticks);
    phase_cur = changed ? pbs_pkg::PHASE_RELEASED : phase;
    events.press = !level && (ticks_next >= press_threshold)
                   && (phase_cur == pbs_pkg::PHASE_RELEASED);
    // hold only in a tick without a press
    events.hold = !level && !events.press && (ticks_next >= hold_threshold)
                  && ((phase_cur == pbs_pkg::PHASE_RELEASED)
                      || (phase_cur == pbs_pkg::PHASE_PRESSED));
    if (events.press) begin
      phase_next = pbs_pkg::PHASE_PRESSED;
    end else if (events.hold) begin
      phase_next = pbs_pkg::PHASE_HELD;
    end else begin
      phase_next = phase_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level <= 1'b1;
      phase <= pbs_pkg::PHASE_RELEASED;
      ticks <= '0;
    end else if (advance) begin
      last_level <= level;
      phase <= phase_next;
      ticks <= ticks_next;
    end
  end

endmodule
`default_nettype wire

[src/power_button_sequencer.sv]
`default_nettype none
// Power button sequencer: one word on the tick channel per millisecond tick.
// A tick word is taken into the input register at the accepting edge; the result register
// takes its result word at a later edge, once the result register is free.
// Throughput: one tick word per cycle unless the result stalls, which holds the result register.
// Reset (rst, synchronous): thresholds and pulse length return to 10, 2000, 30;
// regulators off, no pulse, button seen as released.
module power_button_sequencer (
  input wire logic     clk,
  input wire logic     rst,
  pbs_cfg_if.sink      cfg,
  pbs_tick_if.sink     tick,
  pbs_result_if.source result
);

  pbs_pkg::count_t press_threshold;
  pbs_pkg::count_t hold_threshold;
  pbs_pkg::count_t pulse_length;

  logic s1_valid;
  logic s1_level;
  logic s1_remote;
  logic s1_done;

  logic out_valid;
  logic out_regulators;
  logic out_request;
  logic out_press;
  logic out_hold;

  logic            regulator_flag;
  logic            pulse_active;
  pbs_pkg::count_t pulse_ticks;

  logic                   out_free;
  logic                   advance;
  logic                   tick_fire;
  pbs_pkg::button_event_t events;

  logic            reg_next;
  logic            start_pulse;
  logic            pulse_active_next;
  pbs_pkg::count_t pulse_ticks_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_threshold <= pbs_pkg::PRESS_THRESHOLD_RESET;
      hold_threshold <= pbs_pkg::HOLD_THRESHOLD_RESET;
      pulse_length <= pbs_pkg::PULSE_LENGTH_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        pbs_pkg::REG_PRESS_THRESHOLD: press_threshold <= cfg.data;
        pbs_pkg::REG_HOLD_THRESHOLD:  hold_threshold <= cfg.data;
        pbs_pkg::REG_PULSE_LENGTH:    pulse_length <= cfg.data;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid || result.ready;
  assign advance = s1_valid && out_free;
  assign tick.ready = !s1_valid || out_free;
  assign tick_fire = tick.valid && tick.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      s1_level <= tick.button_level;
      s1_remote <= tick.remote_request;
      s1_done <= tick.shutdown_done;
    end
  end

  pbs_button u_button (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .level           (s1_level),
    .press_threshold (press_threshold),
    .hold_threshold  (hold_threshold),
    .events          (events)
  );

  always_comb begin
    // age a running pulse before this tick's events
    pulse_active_next = pulse_active;
    pulse_ticks_next = pulse_ticks;
    if (pulse_active) begin
      pulse_ticks_next = pbs_pkg::sat_inc(pulse_ticks);
      if (pulse_ticks_next >= pulse_length) begin
        pulse_active_next = 1'b0;
      end
    end

    // press, hold, request, shutdown-complete in that order
    reg_next = regulator_flag;
    start_pulse = 1'b0;
    if (events.press) begin
      if (reg_next) begin
        start_pulse = 1'b1;
      end else begin
        reg_next = 1'b1;
      end
    end
    if (events.hold) begin
      reg_next = 1'b0;
    end
    if (s1_remote) begin
      if (reg_next) begin
        start_pulse = 1'b1;
      end else begin
        reg_next = 1'b1;
      end
    end
    if (s1_done) begin
      reg_next = 1'b0;
    end

    if (start_pulse) begin
      pulse_active_next = 1'b1;
      pulse_ticks_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regulator_flag <= 1'b0;
      pulse_active <= 1'b0;
      pulse_ticks <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        regulator_flag <= reg_next;
        pulse_active <= pulse_active_next;
        pulse_ticks <= pulse_ticks_next;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_regulators <= reg_next;
      out_request <= pulse_active_next;
      out_press <= events.press;
      out_hold <= events.hold;
    end
  end

  assign result.valid = out_valid;
  assign result.regulators_enabled = out_regulators;
  assign result.power_request_line = out_request;
  assign result.press_event = out_press;
  assign result.hold_event = out_hold;

endmodule
`default_nettype wire
